// ----- sv/frsp_pkg.sv -----
// Shared constants and types of the FTP reply stream parser.
package frsp_pkg;

   localparam int LINE_MAX = 1024;
   localparam int TEXT_MAX = 4096;
   localparam int LC_W     = $clog2(LINE_MAX);
   localparam int TC_W     = $clog2(TEXT_MAX);
   localparam int MAXRES   = 5;
   localparam int NT_W     = $clog2(MAXRES + 1);
   localparam int QDEPTH   = 4;
   localparam int QA_W     = $clog2(QDEPTH);

   localparam logic [7:0] CH_CR     = 8'h0d;
   localparam logic [7:0] CH_LF     = 8'h0a;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_HYPHEN = 8'h2d;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_NINE   = 8'h39;

   // result kinds
   localparam logic [1:0] KIND_TEXT  = 2'd0;
   localparam logic [1:0] KIND_DONE  = 2'd1;
   localparam logic [1:0] KIND_ERROR = 2'd2;

   // error codes
   localparam logic [1:0] ERR_MALFORMED = 2'd0;
   localparam logic [1:0] ERR_LINE      = 2'd1;
   localparam logic [1:0] ERR_TEXT      = 2'd2;

   // what follows the text bytes of an item
   localparam logic [1:0] TAIL_NONE  = 2'd0;
   localparam logic [1:0] TAIL_DONE  = 2'd1;
   localparam logic [1:0] TAIL_ERROR = 2'd2;

   // line classes
   localparam logic [1:0] CLS_UNDECIDED = 2'd0;
   localparam logic [1:0] CLS_SKIP      = 2'd1;
   localparam logic [1:0] CLS_WHOLE     = 2'd2;
   localparam logic [1:0] CLS_END       = 2'd3;

   typedef struct packed {
      logic [NT_W-1:0]         ntext;
      logic [MAXRES-1:0][7:0]  text;
      logic [1:0]              tail;
      logic [1:0]              err;
      logic [9:0]              code;
      logic                    multi;
   } job_type;

   typedef struct packed {
      logic    push;
      job_type job;
   } push_type;

   typedef struct packed {
      logic    valid;
      job_type job;
   } head_type;

endpackage

// ----- sv/frsp_front.sv -----
// Front part: takes one byte per cycle while not stalled, tracks line and reply state, builds result jobs.
module frsp_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                stall,
   input  logic [7:0]          req_in_byte,
   output frsp_pkg::push_type  push_out
);

   logic                          in_reply_ff, in_reply_in;
   logic                          multi_ff, multi_in;
   logic [11:0]                   code_ff, code_in;
   logic                          after_cr_ff, after_cr_in;
   logic [frsp_pkg::LC_W-1:0]     line_count_ff, line_count_in;
   logic [3:0][7:0]               held_ff, held_in;
   logic [frsp_pkg::TC_W-1:0]     text_count_ff, text_count_in;
   logic [1:0]                    class_ff, class_in;

   logic                          accept;
   logic                          swallow;
   logic                          is_eol;
   logic                          sep_on;
   logic                          digits;
   logic [11:0]                   got;
   logic [3:0][7:0]               pfx;
   logic                          emit_pfx;
   logic [frsp_pkg::NT_W-1:0]     pfx_n;
   logic                          emit_ch;
   logic [frsp_pkg::MAXRES-1:0][7:0] txt;
   logic [frsp_pkg::NT_W-1:0]     nt;
   logic [frsp_pkg::NT_W-1:0]     nt_out;
   logic [frsp_pkg::TC_W-1:0]     avail;
   logic [1:0]                    tail;
   logic [1:0]                    err;
   logic                          go_idle;
   logic [7:0]                    ch;

   function automatic logic is_digit(input logic [7:0] c);
      is_digit = c inside {[frsp_pkg::CH_ZERO:frsp_pkg::CH_NINE]};
   endfunction

   assign accept = req_valid && !stall;
   assign ch     = req_in_byte;

   always_comb begin
      in_reply_in   = in_reply_ff;
      multi_in      = multi_ff;
      code_in       = code_ff;
      line_count_in = line_count_ff;
      held_in       = held_ff;
      text_count_in = text_count_ff;
      class_in      = class_ff;
      after_cr_in   = (ch == frsp_pkg::CH_CR);
      swallow       = after_cr_ff && (ch == frsp_pkg::CH_LF);
      is_eol        = (ch == frsp_pkg::CH_CR) || (ch == frsp_pkg::CH_LF);
      sep_on        = (text_count_ff != '0);
      digits        = is_digit(held_ff[0]) && is_digit(held_ff[1]) && is_digit(held_ff[2]);
      got           = {held_ff[0][3:0], held_ff[1][3:0], held_ff[2][3:0]};
      pfx           = {ch, held_ff[2], held_ff[1], held_ff[0]};
      emit_pfx      = 1'b0;
      pfx_n         = '0;
      emit_ch       = 1'b0;
      tail          = frsp_pkg::TAIL_NONE;
      err           = frsp_pkg::ERR_MALFORMED;
      go_idle       = 1'b0;

      if (!swallow) begin
         if (is_eol) begin
            line_count_in = '0;
            class_in      = frsp_pkg::CLS_UNDECIDED;
            case (class_ff)
               frsp_pkg::CLS_UNDECIDED: begin
                  if (!in_reply_ff) begin
                     tail    = frsp_pkg::TAIL_ERROR;
                     go_idle = 1'b1;
                  end else begin
                     // short line inside a reply: held bytes become text
                     emit_pfx = 1'b1;
                     pfx_n    = frsp_pkg::NT_W'(line_count_ff[1:0]);
                  end
               end
               frsp_pkg::CLS_WHOLE: begin
                  if (!in_reply_ff) begin
                     tail    = frsp_pkg::TAIL_ERROR;
                     go_idle = 1'b1;
                  end
               end
               frsp_pkg::CLS_END: begin
                  tail    = frsp_pkg::TAIL_DONE;
                  go_idle = 1'b1;
               end
               default: ;
            endcase
         end else if (line_count_ff >= frsp_pkg::LC_W'(frsp_pkg::LINE_MAX - 1)) begin
            tail    = frsp_pkg::TAIL_ERROR;
            err     = frsp_pkg::ERR_LINE;
            go_idle = 1'b1;
         end else if (class_ff != frsp_pkg::CLS_UNDECIDED) begin
            line_count_in = line_count_ff + 1'b1;
            emit_ch       = !((class_ff == frsp_pkg::CLS_WHOLE) && !in_reply_ff);
         end else begin
            held_in[line_count_ff[1:0]] = ch;
            line_count_in = line_count_ff + 1'b1;
            if (line_count_ff == frsp_pkg::LC_W'(3)) begin
               if (!in_reply_ff) begin
                  if (digits && (ch == frsp_pkg::CH_SPACE || ch == frsp_pkg::CH_HYPHEN)) begin
                     code_in       = got;
                     multi_in      = (ch == frsp_pkg::CH_HYPHEN);
                     in_reply_in   = 1'b1;
                     text_count_in = '0;
                     class_in      = (ch == frsp_pkg::CH_HYPHEN) ? frsp_pkg::CLS_SKIP
                                                                 : frsp_pkg::CLS_END;
                  end else begin
                     class_in = frsp_pkg::CLS_WHOLE;
                  end
               end else if (digits && got != code_ff) begin
                  // code mismatch: drop the reply, swallow the rest of the line
                  in_reply_in   = 1'b0;
                  multi_in      = 1'b0;
                  code_in       = '0;
                  text_count_in = '0;
                  class_in      = frsp_pkg::CLS_WHOLE;
               end else if (digits && ch == frsp_pkg::CH_SPACE) begin
                  class_in = frsp_pkg::CLS_END;
                  emit_pfx = 1'b1;
               end else begin
                  class_in = frsp_pkg::CLS_WHOLE;
                  emit_pfx = 1'b1;
                  pfx_n    = frsp_pkg::NT_W'(4);
               end
            end
         end
      end

      // text list: optional separator, then prefix bytes, or the byte itself
      txt = '0;
      nt  = '0;
      if (emit_ch) begin
         txt[0] = ch;
         nt     = frsp_pkg::NT_W'(1);
      end else if (emit_pfx) begin
         if (sep_on) begin
            txt = {pfx[3], pfx[2], pfx[1], pfx[0], frsp_pkg::CH_LF};
            nt  = pfx_n + 1'b1;
         end else begin
            txt = {8'h00, pfx[3], pfx[2], pfx[1], pfx[0]};
            nt  = pfx_n;
         end
      end

      avail  = frsp_pkg::TC_W'(frsp_pkg::TEXT_MAX - 1) - text_count_ff;
      nt_out = nt;
      if (nt != '0) begin
         if (frsp_pkg::TC_W'(nt) > avail) begin
            nt_out  = avail[frsp_pkg::NT_W-1:0];
            tail    = frsp_pkg::TAIL_ERROR;
            err     = frsp_pkg::ERR_TEXT;
            go_idle = 1'b1;
         end else begin
            text_count_in = text_count_ff + frsp_pkg::TC_W'(nt);
         end
      end

      if (go_idle) begin
         in_reply_in   = 1'b0;
         multi_in      = 1'b0;
         code_in       = '0;
         text_count_in = '0;
         line_count_in = '0;
         class_in      = frsp_pkg::CLS_UNDECIDED;
      end

      push_out.push       = accept && (nt_out != '0 || tail != frsp_pkg::TAIL_NONE);
      push_out.job.ntext  = nt_out;
      push_out.job.text   = txt;
      push_out.job.tail   = tail;
      push_out.job.err    = (tail == frsp_pkg::TAIL_ERROR) ? err : frsp_pkg::ERR_MALFORMED;
      push_out.job.code   = {6'b0, code_ff[11:8]} * 10'd100 + {6'b0, code_ff[7:4]} * 10'd10
                            + {6'b0, code_ff[3:0]};
      push_out.job.multi  = multi_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_reply_ff   <= 1'b0;
         multi_ff      <= 1'b0;
         code_ff       <= '0;
         after_cr_ff   <= 1'b0;
         line_count_ff <= '0;
         text_count_ff <= '0;
         class_ff      <= frsp_pkg::CLS_UNDECIDED;
      end else if (accept) begin
         in_reply_ff   <= in_reply_in;
         multi_ff      <= multi_in;
         code_ff       <= code_in;
         after_cr_ff   <= after_cr_in;
         line_count_ff <= line_count_in;
         text_count_ff <= text_count_in;
         class_ff      <= class_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         held_ff <= held_in;
      end
   end

endmodule

// ----- sv/frsp_queue.sv -----
// Short job queue between the front and back parts.
module frsp_queue (
   input  logic                clock,
   input  logic                reset,
   input  frsp_pkg::push_type  push_in,
   input  logic                pop,
   output logic                full,
   output frsp_pkg::head_type  head
);

   frsp_pkg::job_type          mem_ff [frsp_pkg::QDEPTH];
   logic [frsp_pkg::QA_W-1:0]  wr_ff, wr_in;
   logic [frsp_pkg::QA_W-1:0]  rd_ff, rd_in;
   logic [frsp_pkg::QA_W:0]    count_ff, count_in;
   logic                       do_push;

   assign full       = (count_ff == (frsp_pkg::QA_W+1)'(frsp_pkg::QDEPTH));
   assign do_push    = push_in.push && !full;
   assign head.valid = (count_ff != '0);
   assign head.job   = mem_ff[rd_ff];

   always_comb begin
      wr_in    = do_push ? wr_ff + 1'b1 : wr_ff;
      rd_in    = pop ? rd_ff + 1'b1 : rd_ff;
      count_in = count_ff + {{frsp_pkg::QA_W{1'b0}}, do_push} - {{frsp_pkg::QA_W{1'b0}}, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= push_in.job;
      end
   end

endmodule

// ----- sv/frsp_back.sv -----
// Back part: expands each queued job into result items through an output register.
module frsp_back (
   input  logic                clock,
   input  logic                reset,
   input  frsp_pkg::head_type  head,
   output logic                pop,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [1:0]          rsp_kind,
   output logic [7:0]          rsp_text_byte,
   output logic [9:0]          rsp_reply_code,
   output logic                rsp_multi_flag,
   output logic [1:0]          rsp_error_code,
   output logic                rsp_last
);

   logic                       valid_ff, valid_in;
   logic [frsp_pkg::NT_W-1:0]  idx_ff, idx_in;
   logic [1:0]                 kind_ff, kind_in;
   logic [7:0]                 byte_ff, byte_in;
   logic [9:0]                 code_ff;
   logic                       multi_ff;
   logic [1:0]                 err_ff, err_in;
   logic                       last_ff;
   logic [frsp_pkg::NT_W-1:0]  total;
   logic                       is_last;
   logic                       load;

   always_comb begin
      total   = head.job.ntext
                + frsp_pkg::NT_W'(head.job.tail != frsp_pkg::TAIL_NONE);
      is_last = (idx_ff == total - 1'b1);
      load    = head.valid && (!valid_ff || !rsp_stall);
      pop     = load && is_last;

      if (idx_ff < head.job.ntext) begin
         kind_in = frsp_pkg::KIND_TEXT;
         byte_in = head.job.text[idx_ff];
         err_in  = frsp_pkg::ERR_MALFORMED;
      end else begin
         kind_in = (head.job.tail == frsp_pkg::TAIL_DONE) ? frsp_pkg::KIND_DONE
                                                          : frsp_pkg::KIND_ERROR;
         byte_in = 8'h00;
         err_in  = head.job.err;
      end

      if (load) begin
         valid_in = 1'b1;
         idx_in   = is_last ? '0 : idx_ff + 1'b1;
      end else begin
         valid_in = valid_ff && rsp_stall;
         idx_in   = idx_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         kind_ff  <= kind_in;
         byte_ff  <= byte_in;
         code_ff  <= head.job.code;
         multi_ff <= head.job.multi;
         err_ff   <= err_in;
         last_ff  <= is_last;
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_kind       = kind_ff;
   assign rsp_text_byte  = byte_ff;
   assign rsp_reply_code = code_ff;
   assign rsp_multi_flag = multi_ff;
   assign rsp_error_code = err_ff;
   assign rsp_last       = last_ff;

endmodule

// ----- sv/ftp_reply_stream_parser_top.sv -----
// Top level of the FTP reply stream parser.
// Input channel (req_): one control-channel byte per item on req_in_byte.
// Result channel (rsp_): text bytes (kind 0, LF between lines), reply done (kind 1)
// or error (kind 2), with reply code and multi-line flag; rsp_last marks the last
// result caused by one input byte.
// A byte is taken every cycle while the four-entry job queue has room; req_stall
// is raised only when that queue is full. Bytes that cause no result are still
// taken by the front but push no job.
// With nothing queued ahead of it, the first result of a byte passes through the
// job queue and then the output register before it is on rsp_valid.
// The back part emits one result per cycle while rsp_stall is low, so a byte gives
// 0 to 5 results: a separator plus four held prefix bytes is the longest run.
// rsp_stall freezes the output register; the queue keeps filling meanwhile.
// Reset (synchronous) closes any open reply and empties the queue and output.
module ftp_reply_stream_parser_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_in_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_kind,
   output logic [7:0]  rsp_text_byte,
   output logic [9:0]  rsp_reply_code,
   output logic        rsp_multi_flag,
   output logic [1:0]  rsp_error_code,
   output logic        rsp_last
);

   frsp_pkg::push_type  push;
   frsp_pkg::head_type  head;
   logic                full;
   logic                pop;

   assign req_stall = full;

   frsp_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .stall       (full),
      .req_in_byte (req_in_byte),
      .push_out    (push)
   );

   frsp_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push_in (push),
      .pop     (pop),
      .full    (full),
      .head    (head)
   );

   frsp_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head           (head),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_kind       (rsp_kind),
      .rsp_text_byte  (rsp_text_byte),
      .rsp_reply_code (rsp_reply_code),
      .rsp_multi_flag (rsp_multi_flag),
      .rsp_error_code (rsp_error_code),
      .rsp_last       (rsp_last)
   );

   // reply done and error always close the run of one byte
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind != frsp_pkg::KIND_TEXT |-> rsp_last)
      else $error("done or error item not marked last");

   // text items carry no error code, and no kind beyond error exists
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_kind <= frsp_pkg::KIND_ERROR)
                    && (rsp_kind != frsp_pkg::KIND_TEXT
                        || rsp_error_code == frsp_pkg::ERR_MALFORMED))
      else $error("bad kind or error code on text item");

   // a full queue never accepts, so a push then must be held off
   assert property (@(posedge clock) disable iff (reset)
      full && head.valid |-> !(req_valid && !req_stall))
      else $error("item accepted while the job queue is full");

endmodule

// ----- verif/ftp_reply_stream_parser_tb.sv -----
// Self-checking testbench of the FTP reply stream parser: byte stimulus, reply predictor, checker.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] text_byte;
      logic [9:0] code;
      logic       multi;
      logic [1:0] err;
      logic       last;
   } parse_result_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_in_byte = 8'h00;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [1:0] rsp_kind;
   logic [7:0] rsp_text_byte;
   logic [9:0] rsp_reply_code;
   logic       rsp_multi_flag;
   logic [1:0] rsp_error_code;
   logic       rsp_last;

   ftp_reply_stream_parser_top DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_in_byte    (req_in_byte),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_kind       (rsp_kind),
      .rsp_text_byte  (rsp_text_byte),
      .rsp_reply_code (rsp_reply_code),
      .rsp_multi_flag (rsp_multi_flag),
      .rsp_error_code (rsp_error_code),
      .rsp_last       (rsp_last)
   );

   initial forever #4 clock = ~clock;

   // stimulus and checking bookkeeping
   logic [7:0]       pending_bytes[$];
   parse_result_type awaited_results[$];
   parse_result_type byte_results[$];
   int               bytes_queued = 0;
   int               mismatch_count = 0;
   int               results_seen = 0;
   int               send_idle_pct = 0;
   int               recv_idle_pct = 0;
   bit               byte_taken = 1'b0;

   // parser state as predicted
   logic          open_reply = 1'b0;
   logic          multi_line = 1'b0;
   logic [11:0]   code_bcd = '0;
   logic          cr_pending = 1'b0;
   int unsigned   line_bytes = 0;
   logic [7:0]    prefix[4];
   int unsigned   text_sent = 0;
   logic [1:0]    line_mode = frsp_pkg::CLS_UNDECIDED;

   function automatic logic [9:0] code_decimal();
      int v;
      v = int'(code_bcd[11:8]) * 100 + int'(code_bcd[7:4]) * 10 + int'(code_bcd[3:0]);
      return v[9:0];
   endfunction

   function automatic bit is_digit(input logic [7:0] c);
      return c >= frsp_pkg::CH_ZERO && c <= frsp_pkg::CH_NINE;
   endfunction

   function automatic void add_result(input logic [1:0] kind, input logic [7:0] value,
                                      input logic [1:0] err);
      parse_result_type r;
      if (byte_results.size() >= frsp_pkg::MAXRES)
         return;
      r.kind      = kind;
      r.text_byte = value;
      r.code      = code_decimal();
      r.multi     = multi_line;
      r.err       = err;
      r.last      = 1'b0;
      byte_results.push_back(r);
   endfunction

   function automatic void close_reply();
      open_reply = 1'b0;
      multi_line = 1'b0;
      code_bcd   = '0;
      text_sent  = 0;
      line_bytes = 0;
      line_mode  = frsp_pkg::CLS_UNDECIDED;
   endfunction

   function automatic void report_error(input logic [1:0] err);
      add_result(frsp_pkg::KIND_ERROR, 8'h00, err);
      close_reply();
   endfunction

   function automatic bit send_text(input logic [7:0] value);
      if (text_sent >= frsp_pkg::TEXT_MAX - 1) begin
         report_error(frsp_pkg::ERR_TEXT);
         return 1'b0;
      end
      add_result(frsp_pkg::KIND_TEXT, value, frsp_pkg::ERR_MALFORMED);
      text_sent++;
      return 1'b1;
   endfunction

   // LF between lines only once the reply has some text
   function automatic bit send_separator();
      if (text_sent == 0)
         return 1'b1;
      return send_text(frsp_pkg::CH_LF);
   endfunction

   function automatic void close_line();
      logic [1:0]  mode;
      int unsigned held;
      mode       = line_mode;
      held       = line_bytes;
      line_bytes = 0;
      line_mode  = frsp_pkg::CLS_UNDECIDED;
      case (mode)
         frsp_pkg::CLS_UNDECIDED: begin
            if (!open_reply) begin
               report_error(frsp_pkg::ERR_MALFORMED);
               return;
            end
            if (!send_separator())
               return;
            for (int i = 0; i < held && i < 4; i++)
               if (!send_text(prefix[2'(i)]))
                  return;
         end
         frsp_pkg::CLS_WHOLE: begin
            if (!open_reply)
               report_error(frsp_pkg::ERR_MALFORMED);
         end
         frsp_pkg::CLS_END: begin
            add_result(frsp_pkg::KIND_DONE, 8'h00, frsp_pkg::ERR_MALFORMED);
            close_reply();
         end
         default: ;
      endcase
   endfunction

   function automatic void classify_prefix();
      bit          digits;
      logic [11:0] got;
      digits = is_digit(prefix[0]) && is_digit(prefix[1]) && is_digit(prefix[2]);
      got    = {prefix[0][3:0], prefix[1][3:0], prefix[2][3:0]};
      if (!open_reply) begin
         if (digits && (prefix[3] == frsp_pkg::CH_SPACE || prefix[3] == frsp_pkg::CH_HYPHEN))
         begin
            code_bcd   = got;
            multi_line = (prefix[3] == frsp_pkg::CH_HYPHEN);
            open_reply = 1'b1;
            text_sent  = 0;
            line_mode  = multi_line ? frsp_pkg::CLS_SKIP : frsp_pkg::CLS_END;
         end else begin
            line_mode = frsp_pkg::CLS_WHOLE;
         end
         return;
      end
      if (digits) begin
         if (got != code_bcd) begin
            // wrong code: reply dropped, rest of the line swallowed
            close_reply();
            line_bytes = 4;
            line_mode  = frsp_pkg::CLS_WHOLE;
            return;
         end
         if (prefix[3] == frsp_pkg::CH_SPACE) begin
            line_mode = frsp_pkg::CLS_END;
            void'(send_separator());
            return;
         end
      end
      line_mode = frsp_pkg::CLS_WHOLE;
      if (!send_separator())
         return;
      for (int i = 0; i < 4; i++)
         if (!send_text(prefix[2'(i)]))
            return;
   endfunction

   function automatic void take_line_byte(input logic [7:0] ch);
      if (line_bytes >= frsp_pkg::LINE_MAX - 1) begin
         report_error(frsp_pkg::ERR_LINE);
         return;
      end
      if (line_mode != frsp_pkg::CLS_UNDECIDED) begin
         line_bytes++;
         if (line_mode == frsp_pkg::CLS_WHOLE && !open_reply)
            return;
         void'(send_text(ch));
         return;
      end
      prefix[2'(line_bytes)] = ch;
      line_bytes++;
      if (line_bytes >= 4)
         classify_prefix();
   endfunction

   // works out the results one accepted byte causes and queues them
   function automatic void parse_byte(input logic [7:0] ch);
      parse_result_type r;
      byte_results.delete();
      if (cr_pending) begin
         cr_pending = 1'b0;
         if (ch == frsp_pkg::CH_LF)
            return;
      end
      if (ch == frsp_pkg::CH_CR || ch == frsp_pkg::CH_LF) begin
         close_line();
         cr_pending = (ch == frsp_pkg::CH_CR);
      end else begin
         take_line_byte(ch);
      end
      if (byte_results.size() != 0) begin
         r = byte_results.pop_back();
         r.last = 1'b1;
         byte_results.push_back(r);
      end
      while (byte_results.size() != 0)
         awaited_results.push_back(byte_results.pop_front());
   endfunction

   function automatic void note_mismatch(input string what, input parse_result_type want,
                                         input parse_result_type got);
      if (mismatch_count < 10)
         $display("%0t %s: expected kind %0d byte %h code %0d multi %0d err %0d last %0d",
                  $time, what, want.kind, want.text_byte, want.code, want.multi, want.err,
                  want.last);
      if (mismatch_count < 10)
         $display("   got kind %0d byte %h code %0d multi %0d err %0d last %0d",
                  got.kind, got.text_byte, got.code, got.multi, got.err, got.last);
      mismatch_count++;
   endfunction

   // checker and predictor, both on the rising edge
   always @(posedge clock) begin : monitor
      parse_result_type seen;
      parse_result_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            seen = {rsp_kind, rsp_text_byte, rsp_reply_code, rsp_multi_flag,
                    rsp_error_code, rsp_last};
            results_seen++;
            if (awaited_results.size() == 0) begin
               note_mismatch("result with none expected", '0, seen);
            end else begin
               want = awaited_results.pop_front();
               if (seen.kind !== want.kind || seen.text_byte !== want.text_byte ||
                   seen.code !== want.code || seen.multi !== want.multi ||
                   seen.err !== want.err || seen.last !== want.last)
                  note_mismatch("result mismatch", want, seen);
            end
         end
         if (req_valid && !req_stall) begin
            parse_byte(req_in_byte);
            void'(pending_bytes.pop_front());
            byte_taken = 1'b1;
         end
      end
   end

   // sender
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || byte_taken) begin
         if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_valid   <= 1'b1;
            req_in_byte <= pending_bytes[0];
         end else begin
            req_valid <= 1'b0;
         end
      end
      byte_taken = 1'b0;
   end

   // receiver, with one long hold-off so the job queue fills and stalls the input
   int hold_left = 0;
   bit hold_done = 1'b0;
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else if (!hold_done && results_seen >= 20) begin
         hold_done = 1'b1;
         hold_left = 80;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   function automatic void queue_byte(input logic [7:0] b);
      pending_bytes.push_back(b);
      bytes_queued++;
   endfunction

   function automatic void queue_text(input string s);
      for (int i = 0; i < s.len(); i++)
         queue_byte(s[i]);
   endfunction

   // text bytes: mostly printable, never a line end
   function automatic void queue_random_text(input int n);
      logic [7:0] b;
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(3) != 0) begin
            b = 8'($urandom_range(32, 126));
         end else begin
            b = 8'($urandom_range(255));
            if (b == frsp_pkg::CH_CR || b == frsp_pkg::CH_LF)
               b = b ^ 8'h80;
         end
         queue_byte(b);
      end
   endfunction

   function automatic void queue_eol();
      case ($urandom_range(2))
         0: begin
            queue_byte(frsp_pkg::CH_CR);
            queue_byte(frsp_pkg::CH_LF);
         end
         1: queue_byte(frsp_pkg::CH_CR);
         default: queue_byte(frsp_pkg::CH_LF);
      endcase
   endfunction

   function automatic void queue_code(input logic [7:0] d0, input logic [7:0] d1,
                                      input logic [7:0] d2, input logic [7:0] sep);
      queue_byte(d0);
      queue_byte(d1);
      queue_byte(d2);
      queue_byte(sep);
   endfunction

   // a well-formed reply with random content, now and then with a broken line
   function automatic void queue_reply();
      logic [7:0] d0, d1, d2, other;
      bit         multi;
      int         lines;
      d0    = frsp_pkg::CH_ZERO + 8'($urandom_range(9));
      d1    = frsp_pkg::CH_ZERO + 8'($urandom_range(9));
      d2    = frsp_pkg::CH_ZERO + 8'($urandom_range(9));
      multi = 1'($urandom_range(1));
      queue_code(d0, d1, d2, multi ? frsp_pkg::CH_HYPHEN : frsp_pkg::CH_SPACE);
      queue_random_text($urandom_range(10));
      queue_eol();
      if (!multi)
         return;
      lines = $urandom_range(4);
      for (int i = 0; i < lines; i++) begin
         case ($urandom_range(9))
            0: queue_random_text($urandom_range(3));
            1: begin
               queue_code(d0, d1, d2, frsp_pkg::CH_HYPHEN);
               queue_random_text($urandom_range(8));
            end
            2: begin
               other = 8'(int'(frsp_pkg::CH_ZERO)
                          + (int'(d2 - frsp_pkg::CH_ZERO) + 1 + int'($urandom_range(8))) % 10);
               queue_code(d0, d1, other,
                          $urandom_range(1) ? frsp_pkg::CH_SPACE : frsp_pkg::CH_HYPHEN);
               queue_random_text($urandom_range(6));
            end
            3: begin
               queue_code(d0, d1, d2, 8'h78);
               queue_random_text($urandom_range(6));
            end
            default: queue_random_text($urandom_range(4, 16));
         endcase
         queue_eol();
      end
      queue_code(d0, d1, d2, frsp_pkg::CH_SPACE);
      queue_random_text($urandom_range(8));
      queue_eol();
   endfunction

   function automatic void queue_noise();
      int n;
      n = $urandom_range(1, 12);
      for (int i = 0; i < n; i++)
         case ($urandom_range(6))
            0: queue_byte(frsp_pkg::CH_CR);
            1: queue_byte(frsp_pkg::CH_LF);
            default: queue_byte(8'($urandom_range(255)));
         endcase
   endfunction

   initial begin
      int start;
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 29;
               recv_idle_pct = 53;
               queue_byte(frsp_pkg::CH_LF);                // empty line, no reply open
               queue_byte(8'h00);
               queue_byte(8'hff);
               queue_byte(frsp_pkg::CH_CR);                // short malformed line
               queue_text("230-a");
               queue_byte(frsp_pkg::CH_LF);
               queue_text("x");
               queue_byte(frsp_pkg::CH_CR);                // short line inside a reply
               queue_text("231 ");
               queue_byte(frsp_pkg::CH_CR);                // code mismatch
               queue_text("999 ");
               queue_byte(8'hff);
               queue_byte(frsp_pkg::CH_CR);
               queue_byte(frsp_pkg::CH_LF);
            end
            1: begin
               send_idle_pct = 53;
               recv_idle_pct = 29;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         start = bytes_queued;
         while (bytes_queued - start < 35) begin
            if ($urandom_range(3) != 0)
               queue_reply();
            else
               queue_noise();
         end
         while (pending_bytes.size() != 0)
            @(posedge clock);
      end
      while (awaited_results.size() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatch_count == 0 && awaited_results.size() == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

   initial begin
      #2ms;
      $display("== FAIL ==");
      $finish;
   end

endmodule

// ----- sim.f -----
sv/frsp_pkg.sv
sv/frsp_front.sv
sv/frsp_queue.sv
sv/frsp_back.sv
sv/ftp_reply_stream_parser_top.sv
verif/ftp_reply_stream_parser_tb.sv
